// ===== sv/fclw_pkg.sv =====
// ============================================================================
// fclw_pkg: shared types and microcode for the four-connected line walker
// Holds the item structs, the datapath widths and the sequencer program ROM.
// ============================================================================
`timescale 1ns / 1ps

package fclw_pkg;

    // Grid and datapath widths
    localparam int GRID_SIZE = 32;
    localparam int COORD_W   = 5;
    localparam int ERR_W     = COORD_W + 3;
    localparam int UPC_W     = 3;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [UPC_W-1:0]   t_upc;

    // Input item: start and target cells
    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord goal_x;
        t_coord goal_y;
    } t_in_item;

    // Result item: one path cell
    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   corner_step;
        logic   last_point;
    } t_out_item;

    // Datapath operation selected by a control word
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_MAJ,
        OP_MIN
    } t_op;

    // Branch condition selected by a control word
    typedef enum logic [1:0] {
        C_ALWAYS,
        C_IN,
        C_ERR_NEG,
        C_LAST
    } t_cond;

    // One control word: datapath op, emit controls, two-way branch
    typedef struct packed {
        t_op   op;
        logic  emit;
        logic  corner;
        t_cond cond;
        t_upc  jt;
        t_upc  jf;
    } t_ctl;

    // Program addresses
    localparam t_upc U_IDLE   = 3'd0;
    localparam t_upc U_SETUP  = 3'd1;
    localparam t_upc U_START  = 3'd2;
    localparam t_upc U_MOVE   = 3'd3;
    localparam t_upc U_CORNER = 3'd4;
    localparam t_upc U_CELL   = 3'd5;

    // Program ROM
    function automatic t_ctl ctl_rom(input t_upc a);
        t_ctl w;
        w = '{op: OP_NONE, emit: 1'b0, corner: 1'b0, cond: C_ALWAYS,
              jt: U_IDLE, jf: U_IDLE};
        unique case (a)
            // wait for an item and load it
            U_IDLE: begin
                w = '{op: OP_LOAD, emit: 1'b0, corner: 1'b0, cond: C_IN,
                      jt: U_SETUP, jf: U_IDLE};
            end
            // pick major axis, directions and initial error
            U_SETUP: begin
                w = '{op: OP_SETUP, emit: 1'b0, corner: 1'b0, cond: C_ALWAYS,
                      jt: U_START, jf: U_START};
            end
            // emit start cell, done if already at target
            U_START: begin
                w = '{op: OP_NONE, emit: 1'b1, corner: 1'b0, cond: C_LAST,
                      jt: U_IDLE, jf: U_MOVE};
            end
            // step major axis, skip corner when error is negative
            U_MOVE: begin
                w = '{op: OP_MAJ, emit: 1'b0, corner: 1'b0, cond: C_ERR_NEG,
                      jt: U_CELL, jf: U_CORNER};
            end
            // emit corner cell, then step minor axis
            U_CORNER: begin
                w = '{op: OP_MIN, emit: 1'b1, corner: 1'b1, cond: C_ALWAYS,
                      jt: U_CELL, jf: U_CELL};
            end
            // emit path cell, loop until target reached
            U_CELL: begin
                w = '{op: OP_NONE, emit: 1'b1, corner: 1'b0, cond: C_LAST,
                      jt: U_IDLE, jf: U_MOVE};
            end
            default: begin
                w = '{op: OP_NONE, emit: 1'b0, corner: 1'b0, cond: C_ALWAYS,
                      jt: U_IDLE, jf: U_IDLE};
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/four_connected_line_walker.sv =====
// ============================================================================
// four_connected_line_walker: 4-connected Bresenham line generator
// Emits every cell from a start cell to a target cell, marking corner cells
// and the final cell, under control of a small microcode program.
// ============================================================================
// Each accepted item yields 1 + dmaj + dmin cells, where dmaj and dmin are the
// larger and smaller axis distances; the start cell comes first, a corner cell
// precedes each minor-axis step, and the final cell carries last_point. The
// block takes one item at a time: o_in_ready is high only while the sequencer
// sits at its idle step. For each item the sequencer loads it, sets up the
// major axis, directions and initial error, and emits the start cell; its
// microcode loop then steps the major axis and emits the cell, with an extra
// step for each corner cell. Coordinates above GRID_SIZE-1 are
// saturated before the walk. Results leave through an output register, so the
// last cell of one path may still wait there while the next item is taken.
`timescale 1ns / 1ps

module four_connected_line_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fclw_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fclw_pkg::t_out_item o_out_item
);

    // Sequencer state
    fclw_pkg::t_upc      r_upc;
    fclw_pkg::t_upc      n_upc;
    fclw_pkg::t_ctl      w_ctl;
    logic                w_stall;
    logic                w_cond;
    logic                w_last;

    // Datapath registers
    fclw_pkg::t_coord    r_pos_maj;
    fclw_pkg::t_coord    r_pos_min;
    fclw_pkg::t_coord    r_tgt_maj;
    fclw_pkg::t_coord    r_tgt_min;
    fclw_pkg::t_coord    r_dmaj;
    fclw_pkg::t_coord    r_dmin;
    logic                r_maj_y;
    logic                r_smaj_neg;
    logic                r_smin_neg;
    logic signed [fclw_pkg::ERR_W-1:0] r_err;

    // Setup helpers
    fclw_pkg::t_coord    w_dx;
    fclw_pkg::t_coord    w_dy;
    logic                w_swap;
    fclw_pkg::t_coord    w_dbig;
    fclw_pkg::t_coord    w_dsml;
    logic signed [fclw_pkg::ERR_W-1:0] w_dmin2;
    logic signed [fclw_pkg::ERR_W-1:0] w_dmaj2;
    logic signed [fclw_pkg::ERR_W-1:0] w_dbig1;
    logic signed [fclw_pkg::ERR_W-1:0] w_dsml2;

    // Output register
    logic                r_out_valid;
    fclw_pkg::t_out_item r_out_item;

    // Saturate a coordinate to the grid
    function automatic fclw_pkg::t_coord clamp(input fclw_pkg::t_coord v);
        fclw_pkg::t_coord lim;
        lim = fclw_pkg::COORD_W'(fclw_pkg::GRID_SIZE - 1);
        return (v > lim) ? lim : v;
    endfunction

    // Fetch control word
    assign w_ctl      = fclw_pkg::ctl_rom(r_upc);
    assign o_in_ready = (r_upc == fclw_pkg::U_IDLE);

    // Hold the step while an emit finds the output slot occupied
    assign w_stall = w_ctl.emit && r_out_valid && !i_out_ready;
    assign w_last  = (r_pos_maj == r_tgt_maj);

    // Branch condition
    always_comb begin
        unique case (w_ctl.cond)
            fclw_pkg::C_ALWAYS:  w_cond = 1'b1;
            fclw_pkg::C_IN:      w_cond = i_in_valid;
            fclw_pkg::C_ERR_NEG: w_cond = r_err[fclw_pkg::ERR_W-1];
            fclw_pkg::C_LAST:    w_cond = w_last;
            default:             w_cond = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        if (w_stall) begin
            n_upc = r_upc;
        end else begin
            n_upc = w_cond ? w_ctl.jt : w_ctl.jf;
        end
    end

    // Axis distances and error terms
    assign w_dx    = (r_tgt_maj >= r_pos_maj) ? (r_tgt_maj - r_pos_maj)
                                              : (r_pos_maj - r_tgt_maj);
    assign w_dy    = (r_tgt_min >= r_pos_min) ? (r_tgt_min - r_pos_min)
                                              : (r_pos_min - r_tgt_min);
    assign w_swap  = (w_dx < w_dy);
    assign w_dbig  = w_swap ? w_dy : w_dx;
    assign w_dsml  = w_swap ? w_dx : w_dy;
    assign w_dbig1 = $signed(fclw_pkg::ERR_W'(w_dbig));
    assign w_dsml2 = $signed(fclw_pkg::ERR_W'({w_dsml, 1'b0}));
    assign w_dmin2 = $signed(fclw_pkg::ERR_W'({r_dmin, 1'b0}));
    assign w_dmaj2 = $signed(fclw_pkg::ERR_W'({r_dmaj, 1'b0}));

    // Sequencer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= fclw_pkg::U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            unique case (w_ctl.op)
                fclw_pkg::OP_LOAD: begin
                    if (i_in_valid) begin
                        r_pos_maj <= clamp(i_in_item.start_x);
                        r_pos_min <= clamp(i_in_item.start_y);
                        r_tgt_maj <= clamp(i_in_item.goal_x);
                        r_tgt_min <= clamp(i_in_item.goal_y);
                    end
                end
                fclw_pkg::OP_SETUP: begin
                    r_maj_y <= w_swap;
                    r_dmaj  <= w_dbig;
                    r_dmin  <= w_dsml;
                    r_err   <= w_dsml2 - w_dbig1;
                    if (w_swap) begin
                        r_pos_maj  <= r_pos_min;
                        r_pos_min  <= r_pos_maj;
                        r_tgt_maj  <= r_tgt_min;
                        r_tgt_min  <= r_tgt_maj;
                        r_smaj_neg <= !(r_pos_min < r_tgt_min);
                        r_smin_neg <= !(r_pos_maj < r_tgt_maj);
                    end else begin
                        r_smaj_neg <= !(r_pos_maj < r_tgt_maj);
                        r_smin_neg <= !(r_pos_min < r_tgt_min);
                    end
                end
                fclw_pkg::OP_MAJ: begin
                    r_pos_maj <= r_smaj_neg ? (r_pos_maj - 1'b1) : (r_pos_maj + 1'b1);
                    if (r_err[fclw_pkg::ERR_W-1]) begin
                        r_err <= r_err + w_dmin2;
                    end
                end
                fclw_pkg::OP_MIN: begin
                    r_pos_min <= r_smin_neg ? (r_pos_min - 1'b1) : (r_pos_min + 1'b1);
                    r_err     <= r_err + w_dmin2 - w_dmaj2;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: load on emit, drop on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_stall && w_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall && w_ctl.emit) begin
            r_out_item.point_x     <= r_maj_y ? r_pos_min : r_pos_maj;
            r_out_item.point_y     <= r_maj_y ? r_pos_maj : r_pos_min;
            r_out_item.corner_step <= w_ctl.corner;
            r_out_item.last_point  <= !w_ctl.corner && w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/fclw_checker.sv =====
// ============================================================================
// fclw_checker: port-level checks for the four-connected line walker
// Watches the handshakes and result cells seen at the top-level ports.
// ============================================================================
`timescale 1ns / 1ps

module fclw_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  fclw_pkg::t_in_item  i_in_item,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  fclw_pkg::t_out_item o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Drop input ready once an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after an accept");

    // A corner cell is never the final cell
    a_corner_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.corner_step |-> !o_out_item.last_point)
        else $error("corner cell marked last");

    // Cells stay on the grid
    a_on_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_item.point_x <= fclw_pkg::COORD_W'(fclw_pkg::GRID_SIZE - 1)) &&
            (o_out_item.point_y <= fclw_pkg::COORD_W'(fclw_pkg::GRID_SIZE - 1)))
        else $error("result cell off the grid");

endmodule

bind four_connected_line_walker fclw_checker u_fclw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
